/* rtl/assert_macros.svh */
// assertion macros used by the scan sequencer (trgt_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define TRGT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("trgt assertion failed");

// consequent must hold in the cycle after the antecedent
`define TRGT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("trgt assertion failed");

`endif

/* rtl/trgt_pkg.sv */
// shared types and constants for the trust record generation table
`default_nettype none
package trgt_pkg;

	// default table geometry
	localparam int RECORD_SLOTS_DEF = 16;
	localparam int KEY_BYTES_DEF    = 8;

	// operation codes
	localparam logic [1:0] OP_INSTALL = 2'd0;
	localparam logic [1:0] OP_REVOKE  = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;

	// generation counter saturation point
	localparam logic [63:0] GEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] remote_key;
		logic [63:0] query_generation;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] new_generation;
		logic        is_current;
		logic        invalidate_valid;
		logic [63:0] invalidate_generation;
	} rsp_t;

	// command from the sequencer to the record store
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} tbl_cmd_t;

endpackage
`default_nettype wire

/* rtl/trgt_table.sv */
// record store: key and generation memories plus occupied flags
`default_nettype none
module trgt_table
	import trgt_pkg::*;
#(
	parameter int RECORD_SLOTS = RECORD_SLOTS_DEF,
	parameter int KEY_BYTES    = KEY_BYTES_DEF,
	localparam int IDX_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1,
	localparam int KEY_W = KEY_BYTES * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tbl_cmd_t         cmd,
	input  wire logic [IDX_W-1:0] rd_idx,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire logic [KEY_W-1:0] wr_key,
	input  wire logic [63:0]      wr_gen,
	output logic [KEY_W-1:0]      rd_key,
	output logic [63:0]           rd_gen,
	output logic                  rd_occ
);

	logic [KEY_W-1:0]        keys_mem [RECORD_SLOTS];
	logic [63:0]             gens_mem [RECORD_SLOTS];
	logic [RECORD_SLOTS-1:0] occ_q;
	logic [KEY_W-1:0]        rd_key_q;
	logic [63:0]             rd_gen_q;
	logic                    rd_occ_q;

	// memory write port
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			keys_mem[wr_idx] <= wr_key;
			gens_mem[wr_idx] <= wr_gen;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_key_q <= keys_mem[rd_idx];
			rd_gen_q <= gens_mem[rd_idx];
			rd_occ_q <= occ_q[rd_idx];
		end
	end

	// occupied flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.wr) begin
			occ_q[wr_idx] <= 1'b1;
		end else if (cmd.clr) begin
			occ_q[wr_idx] <= 1'b0;
		end
	end

	assign rd_key = rd_key_q;
	assign rd_gen = rd_gen_q;
	assign rd_occ = rd_occ_q;

endmodule
`default_nettype wire

/* rtl/trgt_ctrl.sv */
// scan sequencer with shared compare unit and generation counter
`default_nettype none
module trgt_ctrl
	import trgt_pkg::*;
#(
	parameter int RECORD_SLOTS = RECORD_SLOTS_DEF,
	parameter int KEY_BYTES    = KEY_BYTES_DEF,
	localparam int IDX_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1,
	localparam int KEY_W = KEY_BYTES * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  res_vld,
	input  wire logic             res_ok,
	output rsp_t                  res,
	output tbl_cmd_t              cmd,
	output logic [IDX_W-1:0]      rd_idx,
	output logic [IDX_W-1:0]      wr_idx,
	output logic [KEY_W-1:0]      wr_key,
	output logic [63:0]           wr_gen,
	input  wire logic [KEY_W-1:0] rd_key,
	input  wire logic [63:0]      rd_gen,
	input  wire logic             rd_occ
);
`include "assert_macros.svh"

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_SLOTS - 1);

	logic [1:0]       state_q;
	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [63:0]      qgen_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic             issue_done_q;
	logic             cmp_vld_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [63:0]      hit_gen_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [63:0]      last_gen_q;

	logic             accept;
	logic             fire;
	logic             key_eq;
	logic             wr_want;
	logic             clr_want;
	logic [63:0]      gen_next;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign res_vld   = (state_q == S_DECIDE);
	assign fire      = res_vld && res_ok;

	// shared compare and increment units
	assign key_eq   = rd_occ && (rd_key == key_q);
	assign gen_next = last_gen_q + 64'd1;

	// decision on the scan outcome
	always_comb begin
		res      = '0;
		wr_want  = 1'b0;
		clr_want = 1'b0;
		case (op_q)
			OP_INSTALL: begin
				if (!hit_q && !free_q) begin
					res.status = ST_FULL;
				end else if (last_gen_q == GEN_MAX) begin
					res.status = ST_EXHAUSTED;
				end else begin
					res.new_generation        = gen_next;
					res.invalidate_valid      = hit_q;
					res.invalidate_generation = hit_q ? hit_gen_q : 64'd0;
					wr_want                   = 1'b1;
				end
			end
			OP_REVOKE: begin
				if (hit_q) begin
					res.invalidate_valid      = 1'b1;
					res.invalidate_generation = hit_gen_q;
					clr_want                  = 1'b1;
				end
			end
			OP_QUERY: begin
				res.is_current = (qgen_q != 64'd0) && hit_q && (hit_gen_q == qgen_q);
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// store commands
	always_comb begin
		cmd.rd  = (state_q == S_SCAN) && !issue_done_q;
		cmd.wr  = fire && wr_want;
		cmd.clr = fire && clr_want;
	end

	assign rd_idx = scan_idx_q;
	assign wr_idx = hit_q ? hit_idx_q : free_idx_q;
	assign wr_key = key_q;
	assign wr_gen = gen_next;

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			key_q  <= req.remote_key[KEY_W-1:0];
			qgen_q <= req.query_generation;
		end
	end

	// sequencer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scan_idx_q   <= '0;
			issue_done_q <= 1'b0;
			cmp_vld_q    <= 1'b0;
			cmp_idx_q    <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
			last_gen_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_SCAN;
						scan_idx_q   <= '0;
						issue_done_q <= 1'b0;
						cmp_vld_q    <= 1'b0;
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
					end
				end
				S_SCAN: begin
					// issue one slot read a cycle
					cmp_vld_q <= !issue_done_q;
					cmp_idx_q <= scan_idx_q;
					if (!issue_done_q) begin
						if (scan_idx_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end else begin
							scan_idx_q <= scan_idx_q + IDX_W'(1);
						end
					end
					// compare the slot read last cycle
					if (cmp_vld_q) begin
						if (key_eq && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= cmp_idx_q;
						end
						if (!rd_occ && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= cmp_idx_q;
						end
						if (cmp_idx_q == LAST_IDX) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
					if (cmd.wr) begin
						last_gen_q <= gen_next;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// generation of the matching record
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN) && cmp_vld_q && key_eq && !hit_q) begin
			hit_gen_q <= rd_gen;
		end
	end

	`TRGT_ASSERT_NEXT(a_gen_only_in_decide, clk, arst_n, state_q != S_DECIDE, $stable(last_gen_q))
	`TRGT_ASSERT(a_write_only_ok, clk, arst_n, !cmd.wr || (res.status == ST_OK && res.new_generation != 64'd0))
	`TRGT_ASSERT(a_inval_needs_hit, clk, arst_n, !(res_vld && res.invalidate_valid) || hit_q)
	`TRGT_ASSERT(a_no_write_and_clear, clk, arst_n, !(cmd.wr && cmd.clr))

endmodule
`default_nettype wire

/* rtl/trust_record_generation_table.sv */
// channel   | handshake                 | payload
// req       | req_valid / req_stall     | req   (op, remote_key, query_generation)
// rsp       | rsp_valid / rsp_stall     | rsp   (status, generations, is_current, invalidate)
//
// an item passes through accept, one slot read per cycle through the single store read
// port, a compare of the last slot read, then the decision.
// the result sits in an output register, so the next item is taken while it waits.
// reset clears the occupied flags and the generation counter at once; no clearing pass.
// a stalled result holds the decision stage until the output register frees.
`default_nettype none
module trust_record_generation_table
	import trgt_pkg::*;
#(
	parameter int RECORD_SLOTS = RECORD_SLOTS_DEF,
	parameter int KEY_BYTES    = KEY_BYTES_DEF,
	localparam int IDX_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1,
	localparam int KEY_W = KEY_BYTES * 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	tbl_cmd_t         cmd;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;
	logic [KEY_W-1:0] wr_key;
	logic [63:0]      wr_gen;
	logic [KEY_W-1:0] rd_key;
	logic [63:0]      rd_gen;
	logic             rd_occ;
	logic             res_vld;
	logic             res_ok;
	rsp_t             res;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	trgt_ctrl #(
		.RECORD_SLOTS(RECORD_SLOTS),
		.KEY_BYTES   (KEY_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_vld  (res_vld),
		.res_ok   (res_ok),
		.res      (res),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.wr_idx   (wr_idx),
		.wr_key   (wr_key),
		.wr_gen   (wr_gen),
		.rd_key   (rd_key),
		.rd_gen   (rd_gen),
		.rd_occ   (rd_occ)
	);

	trgt_table #(
		.RECORD_SLOTS(RECORD_SLOTS),
		.KEY_BYTES   (KEY_BYTES)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rd_idx(rd_idx),
		.wr_idx(wr_idx),
		.wr_key(wr_key),
		.wr_gen(wr_gen),
		.rd_key(rd_key),
		.rd_gen(rd_gen),
		.rd_occ(rd_occ)
	);

	// output register free when empty or its beat leaves this cycle
	assign res_ok = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ok) begin
			rsp_valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ok && res_vld) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

/* verif/tb_trust_record_generation_table.sv */
// testbench for the trust record generation table: directed and random request beats
`default_nettype none
module tb_trust_record_generation_table;
	import trgt_pkg::*;

	localparam int SLOTS = RECORD_SLOTS_DEF;
	localparam logic [63:0] KEY_MASK = (KEY_BYTES_DEF >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * KEY_BYTES_DEF)) - 64'd1);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int PEER_POOL = 24;
	localparam int RANDOM_BEATS = 1075;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		req_t beat;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	trust_record_generation_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// shadow copy of the record table
	logic [63:0] shadow_key [SLOTS];
	logic [63:0] shadow_gen [SLOTS];
	bit          shadow_used [SLOTS];
	int          shadow_count;
	logic [63:0] shadow_last_gen;

	rsp_t awaited_rsp[$];
	int   beats_sent;
	int   results_seen;
	int   mismatches;

	// what the run went through
	int cnt_fresh, cnt_rotate, cnt_full, cnt_exhausted;
	int cnt_revoke_hit, cnt_revoke_miss, cnt_query, cnt_current, cnt_unused;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset once at the start
	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// wait length for one beat; calm stretches run back to back
	function automatic int draw_wait(bit calm);
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	// occupied slot holding a key, or -1
	function automatic int slot_of(logic [63:0] key);
		for (int i = 0; i < SLOTS; i++) begin
			if (shadow_used[i] && shadow_key[i] == key)
				return i;
		end
		return -1;
	endfunction

	// apply one request to the shadow table and return the result it must give
	function automatic rsp_t apply_to_trust_table(req_t r);
		rsp_t o;
		int hit;
		int slot;
		logic [63:0] k;
		o = '0;
		k = r.remote_key & KEY_MASK;
		case (r.op)
		OP_INSTALL: begin
			hit = slot_of(k);
			slot = hit;
			o.status = ST_OK;
			if (hit < 0) begin
				if (shadow_count >= SLOTS) begin
					o.status = ST_FULL;
				end else begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!shadow_used[i]) slot = i;
				end
			end
			// full table wins over an exhausted counter
			if (o.status == ST_OK && shadow_last_gen == GEN_MAX)
				o.status = ST_EXHAUSTED;
			if (o.status == ST_OK) begin
				shadow_last_gen = shadow_last_gen + 64'd1;
				o.new_generation = shadow_last_gen;
				if (hit >= 0) begin
					o.invalidate_valid = 1'b1;
					o.invalidate_generation = shadow_gen[hit];
					cnt_rotate++;
				end else begin
					shadow_count++;
					cnt_fresh++;
				end
				shadow_key[slot] = k;
				shadow_gen[slot] = shadow_last_gen;
				shadow_used[slot] = 1'b1;
			end else if (o.status == ST_FULL) begin
				cnt_full++;
			end else begin
				cnt_exhausted++;
			end
		end
		OP_REVOKE: begin
			hit = slot_of(k);
			if (hit >= 0) begin
				o.invalidate_valid = 1'b1;
				o.invalidate_generation = shadow_gen[hit];
				shadow_used[hit] = 1'b0;
				if (shadow_count > 0)
					shadow_count--;
				cnt_revoke_hit++;
			end else begin
				cnt_revoke_miss++;
			end
		end
		OP_QUERY: begin
			cnt_query++;
			// generation zero is never current
			if (r.query_generation != 64'd0) begin
				hit = slot_of(k);
				if (hit >= 0 && shadow_gen[hit] == r.query_generation) begin
					o.is_current = 1'b1;
					cnt_current++;
				end
			end
		end
		default: begin
			cnt_unused++;
		end
		endcase
		return o;
	endfunction

	function automatic dir_row_t dir_entry(logic [1:0] op, logic [63:0] key,
		logic [63:0] qgen, bit typed, logic [1:0] status = ST_OK,
		logic [63:0] newgen = '0, logic cur = 1'b0, logic invv = 1'b0,
		logic [63:0] invg = '0);
		dir_row_t e;
		e.beat.op = op;
		e.beat.remote_key = key;
		e.beat.query_generation = qgen;
		e.typed = typed;
		e.want.status = status;
		e.want.new_generation = newgen;
		e.want.is_current = cur;
		e.want.invalidate_valid = invv;
		e.want.invalidate_generation = invg;
		return e;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("mismatch on result %0d at %0t: %s", results_seen, $time, what);
	endtask

	task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// present one request beat, hold it until taken, then log what it must return
	task automatic send_beat(req_t beat, bit typed, rsp_t want);
		int gap;
		rsp_t predicted;
		gap = draw_wait((beats_sent / 64) % 3 == 1);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= beat;
		do @(posedge clk); while (req_stall);
		predicted = apply_to_trust_table(beat);
		awaited_rsp.push_back(typed ? want : predicted);
		beats_sent++;
	endtask

	// result side: random stall, then take one beat and check it
	initial begin : result_side
		int hold;
		rsp_t want;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_wait((results_seen / 64) % 3 == 2);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			if (awaited_rsp.size() == 0) begin
				report_mismatch("result beat with nothing awaited");
			end else begin
				want = awaited_rsp.pop_front();
				compare_field("status", 64'(rsp.status), 64'(want.status));
				compare_field("new_generation", rsp.new_generation, want.new_generation);
				compare_field("is_current", 64'(rsp.is_current), 64'(want.is_current));
				compare_field("invalidate_valid", 64'(rsp.invalidate_valid),
					64'(want.invalidate_valid));
				compare_field("invalidate_generation", rsp.invalidate_generation,
					want.invalidate_generation);
			end
			results_seen++;
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("no beat for %0d cycles, %0d results outstanding", QUIET_LIMIT,
			awaited_rsp.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// request side: directed table, then random beats, then drain and verdict
	initial begin : request_side
		dir_row_t dir_rows[$];
		logic [63:0] peer_keys [PEER_POOL];
		req_t beat;
		int install_pct;
		int pick;
		int hit;
		req_valid <= 1'b0;
		req <= '0;
		shadow_count = 0;
		shadow_last_gen = '0;
		foreach (shadow_used[i]) shadow_used[i] = 1'b0;

		// empty table, extreme keys, rotate, stale and zero queries, unused op
		dir_rows.push_back(dir_entry(OP_QUERY, 64'd0, 64'd0, 1'b1));
		dir_rows.push_back(dir_entry(OP_REVOKE, GEN_MAX, 64'd0, 1'b1));
		dir_rows.push_back(dir_entry(OP_INSTALL, 64'd0, GEN_MAX, 1'b1, ST_OK, 64'd1));
		dir_rows.push_back(dir_entry(OP_INSTALL, GEN_MAX, 64'd0, 1'b1, ST_OK, 64'd2));
		dir_rows.push_back(dir_entry(OP_INSTALL, 64'd0, 64'd0, 1'b1, ST_OK, 64'd3, 1'b0,
			1'b1, 64'd1));
		dir_rows.push_back(dir_entry(OP_QUERY, 64'd0, 64'd3, 1'b1, ST_OK, 64'd0, 1'b1));
		dir_rows.push_back(dir_entry(OP_QUERY, 64'd0, 64'd1, 1'b1));
		dir_rows.push_back(dir_entry(OP_UNUSED, GEN_MAX, GEN_MAX, 1'b1));
		dir_rows.push_back(dir_entry(OP_REVOKE, GEN_MAX, GEN_MAX, 1'b1, ST_OK, 64'd0,
			1'b0, 1'b1, 64'd2));
		// fill every remaining slot, then a new key is refused
		for (int i = 1; i < SLOTS; i++)
			dir_rows.push_back(dir_entry(OP_INSTALL, 64'h0101_0101_0101_0101 * i,
				64'd0, 1'b0));
		dir_rows.push_back(dir_entry(OP_INSTALL, 64'h5555_AAAA_5555_AAAA, 64'd0, 1'b1,
			ST_FULL));
		// a known key still rotates on a full table
		dir_rows.push_back(dir_entry(OP_INSTALL, 64'd0, 64'd0, 1'b0));

		// small pool of peers so records get hit, rotated and revoked
		foreach (peer_keys[i]) peer_keys[i] = {$urandom(), $urandom()};
		peer_keys[0] = 64'd0;
		peer_keys[1] = GEN_MAX;

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

		// random beats; phases shift the install share so the table fills and drains
		// the counter saturation path needs 2^64 installs and stays out of reach here
		install_pct = 40;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 100 == 0)
				install_pct = 20 + 20 * $urandom_range(0, 2);
			pick = $urandom_range(0, 99);
			if (pick < install_pct)
				beat.op = OP_INSTALL;
			else if (pick < install_pct + 25)
				beat.op = OP_REVOKE;
			else if (pick < 95)
				beat.op = OP_QUERY;
			else
				beat.op = OP_UNUSED;
			if ($urandom_range(0, 6) == 0)
				beat.remote_key = {$urandom(), $urandom()};
			else
				beat.remote_key = peer_keys[$urandom_range(0, PEER_POOL - 1)];
			beat.query_generation = {$urandom(), $urandom()};
			// queries mostly ask about the live generation or a recent one
			if (beat.op == OP_QUERY) begin
				hit = slot_of(beat.remote_key & KEY_MASK);
				case ($urandom_range(0, 4))
				0, 1: if (hit >= 0) beat.query_generation = shadow_gen[hit];
				2: beat.query_generation = shadow_last_gen - 64'($urandom_range(0, 20));
				3: beat.query_generation = 64'd0;
				default: ;
				endcase
			end
			send_beat(beat, 1'b0, '0);
		end
		req_valid <= 1'b0;

		// drain outstanding results, then let the pipeline settle
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d fresh installs, %0d rotations, %0d refused full, %0d exhausted",
			beats_sent, cnt_fresh, cnt_rotate, cnt_full, cnt_exhausted);
		$display("revokes %0d hit %0d missed, queries %0d (%0d current), unused op %0d",
			cnt_revoke_hit, cnt_revoke_miss, cnt_query, cnt_current, cnt_unused);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
